@@ rtl/pts_pkg.sv @@
// Shared constants and types for the priority tick scheduler.
// No dependencies; compile first.
`default_nettype none
package pts_pkg;

  localparam int MAX_PROCS = 16;
  localparam int IDX_W     = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int CNT_W     = $clog2(MAX_PROCS + 1);
  localparam int PRI_W     = 8;
  localparam int TIME_W    = 16;
  localparam int PIDX_W    = 4;
  localparam int ELAP_W    = 32;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_TICK = 1'b1
  } op_t;

  typedef struct packed {
    logic [PRI_W-1:0]  pri;
    logic [TIME_W-1:0] rem;
  } entry_t;

  typedef struct packed {
    logic load;
    logic scan_start;
    logic scan_read;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic scan_last;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

@@ rtl/pts_if.sv @@
// Valid/ready channel interfaces for the scheduler's request and result beats.
// Depends on pts_pkg.
`default_nettype none
interface pts_req_if
  import pts_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic              operation;
  logic [PRI_W-1:0]  priority_req;
  logic [TIME_W-1:0] need_time;

  modport source (output valid, operation, priority_req, need_time, input ready);
  modport sink   (input valid, operation, priority_req, need_time, output ready);
endinterface

interface pts_rsp_if
  import pts_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic              all_done;
  logic [PIDX_W-1:0] process_index;
  logic [TIME_W-1:0] remaining;
  logic              finished;
  logic [ELAP_W-1:0] finish_time;

  modport source (output valid, all_done, process_index, remaining, finished, finish_time,
                  input ready);
  modport sink   (input valid, all_done, process_index, remaining, finished, finish_time,
                  output ready);
endinterface
`default_nettype wire

@@ rtl/pts_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module pts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ rtl/pts_ctrl.sv @@
// Sequencer for the scheduler: takes request beats, runs the table scan
// and releases the result. Depends on pts_pkg.
`default_nettype none
module pts_ctrl
  import pts_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    req_valid,
  input  wire logic    req_op,
  output logic         req_ready,
  input  wire status_t status,
  output cmd_t         cmd
);
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_EMIT
  } state_t;

  state_t state, state_next;

  always_comb begin
    cmd        = '0;
    req_ready  = 1'b0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          if (req_op == OP_LOAD) begin
            cmd.load = 1'b1;
          end else begin
            cmd.scan_start = 1'b1;
            state_next     = status.empty ? S_EMIT : S_SCAN;
          end
        end
      end
      S_SCAN: begin
        cmd.scan_read = 1'b1;
        if (status.scan_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assert property (@(posedge clk) disable iff (rst) cmd.emit |-> status.out_free)
    else $error("result released while output register is occupied");
  assert property (@(posedge clk) disable iff (rst)
                   (cmd.scan_start && status.empty) |=> !cmd.scan_read)
    else $error("scan started on an empty table");
  assert property (@(posedge clk) disable iff (rst)
                   (cmd.scan_read && status.scan_last) |=> !cmd.scan_read)
    else $error("scan ran past the last loaded entry");
endmodule
`default_nettype wire

@@ rtl/pts_dp.sv @@
// Datapath: process table RAM, entry count, elapsed time, scan compare
// and the result register. Depends on pts_pkg and pts_ram.
`default_nettype none
module pts_dp
  import pts_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire cmd_t              cmd,
  output status_t                status,
  input  wire logic [PRI_W-1:0]  ld_pri,
  input  wire logic [TIME_W-1:0] ld_time,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic                   out_all_done,
  output logic [PIDX_W-1:0]      out_index,
  output logic [TIME_W-1:0]      out_remaining,
  output logic                   out_finished,
  output logic [ELAP_W-1:0]      out_finish_time
);
  logic [CNT_W-1:0]  count;
  logic [ELAP_W-1:0] elapsed;
  logic [IDX_W-1:0]  scan_addr;
  logic              cmp_valid;
  logic [IDX_W-1:0]  cmp_idx;
  logic              found;
  logic [IDX_W-1:0]  best_idx;
  logic [PRI_W-1:0]  best_pri;
  logic [TIME_W-1:0] best_rem;

  logic              full;
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  entry_t            ram_wdata;
  entry_t            ram_rdata;
  logic [TIME_W-1:0] rem_dec;
  logic [ELAP_W-1:0] elapsed_inc;

  assign full        = (count == CNT_W'(MAX_PROCS));
  assign rem_dec     = best_rem - TIME_W'(1);
  assign elapsed_inc = elapsed + ELAP_W'(1);

  assign status.empty     = (count == '0);
  assign status.scan_last = ((CNT_W'(scan_addr) + CNT_W'(1)) == count);
  assign status.out_free  = !out_valid || out_ready;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = best_idx;
    ram_wdata = '{pri: best_pri, rem: rem_dec};
    if (cmd.load) begin
      ram_we    = !full;
      ram_waddr = IDX_W'(count);
      ram_wdata = '{pri: ld_pri, rem: ld_time};
    end else if (cmd.emit && found) begin
      ram_we = 1'b1;
    end
  end

  pts_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (MAX_PROCS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (scan_addr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      elapsed   <= '0;
      cmp_valid <= 1'b0;
      found     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      cmp_valid <= cmd.scan_read;
      if (cmd.load && !full) begin
        count <= count + CNT_W'(1);
      end
      if (cmd.scan_start) begin
        found <= 1'b0;
      end else if (cmp_valid && ram_rdata.rem != '0 && (!found || ram_rdata.pri < best_pri)) begin
        found <= 1'b1;
      end
      if (cmd.emit && found) begin
        elapsed <= elapsed_inc;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      scan_addr <= '0;
    end else if (cmd.scan_read) begin
      scan_addr <= scan_addr + IDX_W'(1);
    end
    cmp_idx <= scan_addr;
    if (cmp_valid && ram_rdata.rem != '0 && (!found || ram_rdata.pri < best_pri)) begin
      best_idx <= cmp_idx;
      best_pri <= ram_rdata.pri;
      best_rem <= ram_rdata.rem;
    end
    if (cmd.emit) begin
      out_all_done    <= !found;
      out_index       <= found ? PIDX_W'(32'(best_idx)) : '0;
      out_remaining   <= found ? rem_dec : '0;
      out_finished    <= found && (rem_dec == '0);
      out_finish_time <= (found && (rem_dec == '0)) ? elapsed_inc : '0;
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= CNT_W'(MAX_PROCS))
    else $error("entry count beyond table size");
  assert property (@(posedge clk) disable iff (rst)
                   (cmd.emit && found) |=> elapsed == $past(elapsed) + ELAP_W'(1))
    else $error("elapsed time did not advance on a run tick");
  assert property (@(posedge clk) disable iff (rst)
                   (cmd.emit && !found) |=> elapsed == $past(elapsed))
    else $error("elapsed time moved on an all-done tick");
endmodule
`default_nettype wire

@@ rtl/priority_tick_scheduler_core.sv @@
// Static-priority preemptive scheduler, top level.
// Depends on pts_pkg, pts_if, pts_ram, pts_ctrl and pts_dp.
//
// A load beat (operation 0) writes the next free table slot and returns no
// result; loads past MAX_PROCS entries are dropped. A tick beat (operation
// 1) scans the loaded entries one per cycle through the table RAM's single
// read port, then passes a drain state (skipped on an empty table) before
// its result enters the output register in the emit state, after any wait
// for that register to be taken. The next request beat is taken once the
// result has been registered.
`default_nettype none
module priority_tick_scheduler_core
  import pts_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  pts_req_if.sink   req,
  pts_rsp_if.source rsp
);
  cmd_t    cmd;
  status_t status;

  pts_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_op    (req.operation),
    .req_ready (req.ready),
    .status    (status),
    .cmd       (cmd)
  );

  pts_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .ld_pri          (req.priority_req),
    .ld_time         (req.need_time),
    .out_valid       (rsp.valid),
    .out_ready       (rsp.ready),
    .out_all_done    (rsp.all_done),
    .out_index       (rsp.process_index),
    .out_remaining   (rsp.remaining),
    .out_finished    (rsp.finished),
    .out_finish_time (rsp.finish_time)
  );
endmodule
`default_nettype wire

@@ tb/tb_top.sv @@
// Self-checking bench for priority_tick_scheduler_core: random load/tick beats,
// expected tick reports kept by an in-bench scheduler predictor.
// Depends on pts_pkg, pts_if and the scheduler RTL.
`timescale 1ns / 100ps
module tb_top;
  import pts_pkg::*;

  localparam int N_RANDOM    = 1935;
  localparam int PHASE_LEN   = 120;
  localparam int HOLD_CYCLES = 300;
  localparam int LIMIT       = 1000000;
  localparam int DRAIN       = 4 * (MAX_PROCS + 3);

  typedef struct packed {
    logic              all_done;
    logic [PIDX_W-1:0] process_index;
    logic [TIME_W-1:0] remaining;
    logic              finished;
    logic [ELAP_W-1:0] finish_time;
  } tick_report_t;

  class run_queue_model;
    logic [PRI_W-1:0]  pri_tab [MAX_PROCS];
    logic [TIME_W-1:0] rem_tab [MAX_PROCS];
    int unsigned       loaded;
    logic [ELAP_W-1:0] elapsed;
    tick_report_t      expected_reports[$];
    int                mismatches;

    function new();
      loaded     = 0;
      elapsed    = '0;
      mismatches = 0;
    endfunction

    function void note_beat(op_t op, logic [PRI_W-1:0] pri, logic [TIME_W-1:0] need);
      tick_report_t r;
      int           best;
      bit           found;
      if (op == OP_LOAD) begin
        if (loaded < MAX_PROCS) begin
          pri_tab[loaded] = pri;
          rem_tab[loaded] = need;
          loaded++;
        end
        return;
      end
      best  = 0;
      found = 0;
      for (int i = 0; i < loaded; i++) begin
        if (rem_tab[i] != '0 && (!found || pri_tab[i] < pri_tab[best])) begin
          best  = i;
          found = 1;
        end
      end
      r = '0;
      if (!found) begin
        r.all_done = 1'b1;
      end else begin
        rem_tab[best]   = rem_tab[best] - 1'b1;
        elapsed         = elapsed + 1'b1;
        r.process_index = best[PIDX_W-1:0];
        if (rem_tab[best] == '0) begin
          r.finished    = 1'b1;
          r.finish_time = elapsed;
        end else begin
          r.remaining = rem_tab[best];
        end
      end
      expected_reports.push_back(r);
    endfunction

    function void cmp_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $error("%s: expected %0d, actual %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(tick_report_t got);
      tick_report_t want;
      if (expected_reports.size() == 0) begin
        $error("result beat with no tick outstanding");
        mismatches++;
        return;
      end
      want = expected_reports.pop_front();
      cmp_field("all_done", want.all_done, got.all_done);
      cmp_field("process_index", want.process_index, got.process_index);
      cmp_field("remaining", want.remaining, got.remaining);
      cmp_field("finished", want.finished, got.finished);
      cmp_field("finish_time", want.finish_time, got.finish_time);
    endfunction

    function int outstanding();
      return expected_reports.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  pts_req_if req_ch ();
  pts_rsp_if rsp_ch ();

  priority_tick_scheduler_core DUT (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  run_queue_model sched = new();

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int item_no        = 0;
  int slots_used     = 0;
  bit hold_pending   = 0;
  int cycles         = 0;

  always #5 clk = ~clk;

  task automatic set_phase();
    case ((item_no / PHASE_LEN) % 4)
      0: begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      1: begin
        send_idle_pct  = 53;
        recv_stall_pct = 0;
      end
      2: begin
        send_idle_pct  = 0;
        recv_stall_pct = 53;
      end
      default: begin
        send_idle_pct  = 22;
        recv_stall_pct = 22;
      end
    endcase
  endtask

  task automatic send_beat(op_t op, logic [PRI_W-1:0] pri, logic [TIME_W-1:0] need);
    set_phase();
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.operation    <= op;
    req_ch.priority_req <= pri;
    req_ch.need_time    <= need;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    sched.note_beat(op, pri, need);
    item_no++;
  endtask

  task automatic load_proc(logic [PRI_W-1:0] pri, logic [TIME_W-1:0] need);
    send_beat(OP_LOAD, pri, need);
    if (slots_used < MAX_PROCS) slots_used++;
  endtask

  task automatic tick_once();
    send_beat(OP_TICK, PRI_W'($urandom()), TIME_W'($urandom()));
  endtask

  // result side: check each beat, then pick ready for the next edge
  initial begin
    tick_report_t got;
    int           hold_left;
    hold_left = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_ch.valid && rsp_ch.ready) begin
        got.all_done      = rsp_ch.all_done;
        got.process_index = rsp_ch.process_index;
        got.remaining     = rsp_ch.remaining;
        got.finished      = rsp_ch.finished;
        got.finish_time   = rsp_ch.finish_time;
        sched.check_result(got);
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else if (hold_pending) begin
        hold_pending = 0;
        hold_left    = HOLD_CYCLES;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  initial begin
    while (cycles < LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    req_ch.valid        <= 1'b0;
    req_ch.operation    <= OP_LOAD;
    req_ch.priority_req <= '0;
    req_ch.need_time    <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty table, then a zero-need entry that never runs
    tick_once();
    load_proc(8'd0, 16'd0);
    tick_once();
    // equal priorities: lower slot first
    load_proc(8'd5, 16'd2);
    load_proc(8'd5, 16'd1);
    repeat (4) tick_once();
    // priority extremes
    load_proc(8'd255, 16'd1);
    load_proc(8'd0, 16'd1);
    repeat (3) tick_once();

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == 60) hold_pending = 1;
      if (slots_used < MAX_PROCS - 1 && ($urandom_range(0, 99) < 2 || n >= 1400)) begin
        load_proc(PRI_W'($urandom_range(0, 255)),
                  ($urandom_range(0, 19) == 0) ? 16'd0 : TIME_W'($urandom_range(1, 120)));
      end else if (slots_used == MAX_PROCS - 1 && n >= 1500) begin
        load_proc(8'd255, 16'hFFFF);
      end else if (slots_used == MAX_PROCS && $urandom_range(0, 9) == 0) begin
        // table full: drop
        load_proc(PRI_W'($urandom()), TIME_W'($urandom()));
      end else begin
        tick_once();
      end
    end
    req_ch.valid <= 1'b0;

    while (sched.outstanding() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (sched.mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
